// ===== rtl/sawbc_pkg.sv =====
package sawbc_pkg;

    // command codes
    localparam logic [1:0] CMD_PRELOAD = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_WRITE   = 2'd2;
    localparam logic [1:0] CMD_FLUSH   = 2'd3;

    // transfer kinds
    localparam logic [2:0] XFER_C2P = 3'd0;
    localparam logic [2:0] XFER_P2C = 3'd1;
    localparam logic [2:0] XFER_M2C = 3'd2;
    localparam logic [2:0] XFER_C2M = 3'd3;
    localparam logic [2:0] XFER_DROP = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_BLOCK_WORDS_LOG2 = 2'd0;
    localparam logic [1:0] REG_SETS_LOG2        = 2'd1;
    localparam logic [1:0] REG_WAYS_LOG2        = 2'd2;

    // storage geometry
    localparam int MEM_WORDS       = 65536;
    localparam int MAX_LINES       = 256;
    localparam int MAX_BLOCK_WORDS = 8;
    localparam int MEM_AW  = $clog2(MEM_WORDS);
    localparam int LINE_AW = $clog2(MAX_LINES);
    localparam int OFF_W   = $clog2(MAX_BLOCK_WORDS);
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        word_address;
        logic signed [31:0] write_word;
        logic [15:0]        access_stamp;
        logic [7:0]         line_set;
        logic [2:0]         line_way;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         transfer_kind;
        logic [15:0]        start_address;
        logic [3:0]         word_count;
        logic signed [31:0] read_word;
        logic               last;
    } out_item_t;

    // class decided by the front end
    typedef enum logic [1:0] {
        CLS_PRELOAD = 2'd0,
        CLS_ACCESS  = 2'd1,
        CLS_FLUSH   = 2'd2,
        CLS_NONE    = 2'd3
    } cls_t;

    typedef struct packed {
        in_item_t item;
        cls_t     cls;
        logic     is_read;
    } q_entry_t;

    // queue handshake toward the back end
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

endpackage

// ===== rtl/sawbc_front.sv =====
module sawbc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sawbc_pkg::in_item_t s_data,
    output sawbc_pkg::q_head_t  q_head,
    input  logic                q_pop
);

    sawbc_pkg::q_entry_t q_mem_reg [sawbc_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    sawbc_pkg::q_entry_t entry_in;
    logic push, pop;

    // classify the incoming transaction
    always_comb begin
        entry_in.item    = s_data;
        entry_in.is_read = (s_data.cmd == sawbc_pkg::CMD_READ);
        case (s_data.cmd)
            sawbc_pkg::CMD_PRELOAD: entry_in.cls = sawbc_pkg::CLS_PRELOAD;
            sawbc_pkg::CMD_READ,
            sawbc_pkg::CMD_WRITE:   entry_in.cls = sawbc_pkg::CLS_ACCESS;
            sawbc_pkg::CMD_FLUSH:   entry_in.cls = sawbc_pkg::CLS_FLUSH;
            default:                entry_in.cls = sawbc_pkg::CLS_NONE;
        endcase
    end

    assign s_ready = (count_reg != 2'(sawbc_pkg::QUEUE_DEPTH));
    assign push = s_valid && s_ready;
    assign pop  = q_pop && (count_reg != 2'd0);
    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.entry = q_mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/sawbc_back.sv =====
module sawbc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_wr_data,
    input  sawbc_pkg::q_head_t   q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sawbc_pkg::out_item_t m_data
);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_SCAN_RD   = 13'b0000000000010,
        ST_SCAN_CHK  = 13'b0000000000100,
        ST_VICT      = 13'b0000000001000,
        ST_WB_RD     = 13'b0000000010000,
        ST_WB_WR     = 13'b0000000100000,
        ST_WB_EMIT   = 13'b0000001000000,
        ST_FILL_RD   = 13'b0000010000000,
        ST_FILL_WR   = 13'b0000100000000,
        ST_FILL_EMIT = 13'b0001000000000,
        ST_ACC       = 13'b0010000000000,
        ST_ACC_EMIT  = 13'b0100000000000,
        ST_FL_TAG    = 13'b1000000000000
    } state_t;

    localparam int LW_AW = sawbc_pkg::LINE_AW + sawbc_pkg::OFF_W;

    // memories
    logic [31:0] bmem [sawbc_pkg::MEM_WORDS];
    logic [31:0] lwords [sawbc_pkg::MAX_LINES * sawbc_pkg::MAX_BLOCK_WORDS];
    logic [15:0] tag_mem [sawbc_pkg::MAX_LINES];
    logic [15:0] stamp_mem [sawbc_pkg::MAX_LINES];

    state_t state_reg, state_next;
    logic [1:0] bw_log2_reg;
    logic [3:0] sets_log2_reg;
    logic [1:0] ways_log2_reg;
    logic [sawbc_pkg::MAX_LINES-1:0] valid_reg, dirty_reg;

    logic [15:0] addr_reg, stamp_reg, wb_base_reg, best_tag_reg;
    logic [31:0] data_reg;
    logic        is_read_reg, is_flush_reg, vict_dirty_reg, found_inv_reg;
    logic [3:0]  way_reg;
    logic [2:0]  j_reg;
    logic [7:0]  line_reg, cur_line_reg, inv_line_reg, best_line_reg;
    logic [15:0] best_stamp_reg;
    logic        m_valid_reg;
    sawbc_pkg::out_item_t m_data_reg;

    logic [31:0] mem_q, lw_q;
    logic [15:0] tag_q, stamp_q;

    // effective geometry
    logic [3:0] eff_s;
    logic [1:0] eff_b, eff_w;
    logic [7:0] set_mask, cur_set, cur_line, fl_line;
    logic [2:0] bs_m1, off;
    logic [3:0] bs, ways;
    logic [15:0] block, fill_base;
    logic        can_emit, fl_ok, emit_fire;

    always_comb begin
        eff_b = bw_log2_reg;
        eff_w = ways_log2_reg;
        eff_s = (sets_log2_reg > 4'd8) ? 4'd8 : sets_log2_reg;
        if (eff_s + 4'(eff_w) > 4'd8) eff_s = 4'd8 - 4'(eff_w);
        set_mask  = 8'((9'd1 << eff_s) - 9'd1);
        bs        = 4'd1 << eff_b;
        bs_m1     = 3'(bs - 4'd1);
        ways      = 4'd1 << eff_w;
        block     = addr_reg >> eff_b;
        fill_base = addr_reg & ~16'(bs_m1);
        off       = addr_reg[2:0] & bs_m1;
        cur_set   = block[7:0] & set_mask;
        cur_line  = 8'((cur_set << eff_w) | 8'(way_reg));
        fl_line   = 8'((q_head.entry.item.line_set << eff_w)
                       | 8'(q_head.entry.item.line_way));
        fl_ok     = ({1'b0, q_head.entry.item.line_set} < (9'd1 << eff_s))
                    && ({1'b0, q_head.entry.item.line_way} < ways);
        can_emit  = !m_valid_reg || m_ready;
        emit_fire = can_emit
                    && (state_reg inside {ST_WB_EMIT, ST_FILL_EMIT, ST_ACC_EMIT});
    end

    // memory port controls
    logic            bm_we, bm_re, lw_we, lw_re, tg_we, tg_re, st_we, st_re;
    logic [15:0]     bm_wa, bm_ra;
    logic [31:0]     bm_wd, lw_wd;
    logic [LW_AW-1:0] lw_wa, lw_ra;
    logic [7:0]      tg_a, st_a;

    always_comb begin
        bm_we = 1'b0; bm_wa = fill_base + 16'(j_reg); bm_wd = lw_q;
        bm_re = 1'b0; bm_ra = fill_base + 16'(j_reg);
        lw_we = 1'b0; lw_wa = {line_reg, j_reg}; lw_wd = mem_q;
        lw_re = 1'b0; lw_ra = {line_reg, j_reg};
        tg_we = 1'b0; tg_re = 1'b0; tg_a = cur_line;
        st_we = 1'b0; st_re = 1'b0; st_a = cur_line;
        case (state_reg)
            ST_IDLE: begin
                if (q_head.valid && q_head.entry.cls == sawbc_pkg::CLS_PRELOAD) begin
                    bm_we = 1'b1;
                    bm_wa = q_head.entry.item.word_address;
                    bm_wd = q_head.entry.item.write_word;
                end
                if (q_head.valid && q_head.entry.cls == sawbc_pkg::CLS_FLUSH) begin
                    tg_re = 1'b1;
                    tg_a  = fl_line;
                end
            end
            ST_SCAN_RD: begin
                tg_re = 1'b1;
                st_re = 1'b1;
            end
            ST_WB_RD: lw_re = 1'b1;
            ST_WB_WR: begin
                bm_we = 1'b1;
                bm_wa = wb_base_reg + 16'(j_reg);
            end
            ST_FILL_RD: bm_re = 1'b1;
            ST_FILL_WR: lw_we = 1'b1;
            ST_FILL_EMIT: begin
                tg_we = can_emit;
                tg_a  = line_reg;
            end
            ST_ACC: begin
                st_we = 1'b1;
                st_a  = line_reg;
                lw_re = is_read_reg;
                lw_ra = {line_reg, off};
                lw_we = !is_read_reg;
                lw_wa = {line_reg, off};
                lw_wd = data_reg;
            end
            default: ;
        endcase
    end

    // backing memory
    always_ff @(posedge aclk) begin
        if (bm_we) bmem[bm_wa] <= bm_wd;
        if (bm_re) mem_q <= bmem[bm_ra];
    end

    // line data memory
    always_ff @(posedge aclk) begin
        if (lw_we) lwords[lw_wa] <= lw_wd;
        if (lw_re) lw_q <= lwords[lw_ra];
    end

    // tag and stamp memories
    always_ff @(posedge aclk) begin
        if (tg_we) tag_mem[tg_a] <= block;
        if (tg_re) tag_q <= tag_mem[tg_a];
        if (st_we) stamp_mem[st_a] <= stamp_reg;
        if (st_re) stamp_q <= stamp_mem[st_a];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        q_pop = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_head.valid) begin
                    q_pop = 1'b1;
                    if (q_head.entry.cls == sawbc_pkg::CLS_ACCESS) begin
                        state_next = ST_SCAN_RD;
                    end else if (q_head.entry.cls == sawbc_pkg::CLS_FLUSH && fl_ok
                                 && valid_reg[fl_line] && dirty_reg[fl_line]) begin
                        state_next = ST_FL_TAG;
                    end
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (valid_reg[cur_line_reg] && tag_q == block) begin
                    state_next = ST_ACC;
                end else if (way_reg == ways - 4'd1) begin
                    state_next = ST_VICT;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_VICT: begin
                if (found_inv_reg) state_next = ST_FILL_RD;
                else if (dirty_reg[best_line_reg]) state_next = ST_WB_RD;
                else state_next = ST_WB_EMIT;
            end
            ST_WB_RD: state_next = ST_WB_WR;
            ST_WB_WR: state_next = (j_reg == bs_m1) ? ST_WB_EMIT : ST_WB_RD;
            ST_WB_EMIT: begin
                if (can_emit) state_next = is_flush_reg ? ST_IDLE : ST_FILL_RD;
            end
            ST_FILL_RD: state_next = ST_FILL_WR;
            ST_FILL_WR: state_next = (j_reg == bs_m1) ? ST_FILL_EMIT : ST_FILL_RD;
            ST_FILL_EMIT: if (can_emit) state_next = ST_ACC;
            ST_ACC: state_next = ST_ACC_EMIT;
            ST_ACC_EMIT: if (can_emit) state_next = ST_IDLE;
            ST_FL_TAG: state_next = ST_WB_RD;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                addr_reg     <= q_head.entry.item.word_address;
                data_reg     <= q_head.entry.item.write_word;
                stamp_reg    <= q_head.entry.item.access_stamp;
                is_read_reg  <= q_head.entry.is_read;
                is_flush_reg <= 1'b1;
                line_reg     <= fl_line;
                way_reg      <= 4'd0;
                j_reg        <= 3'd0;
                found_inv_reg  <= 1'b0;
                vict_dirty_reg <= 1'b1;
            end
            ST_SCAN_RD: cur_line_reg <= cur_line;
            ST_SCAN_CHK: begin
                is_flush_reg <= 1'b0;
                line_reg <= cur_line_reg;
                way_reg  <= way_reg + 4'd1;
                if (!valid_reg[cur_line_reg] && !found_inv_reg) begin
                    found_inv_reg <= 1'b1;
                    inv_line_reg  <= cur_line_reg;
                end
                if (way_reg == 4'd0 || stamp_q < best_stamp_reg) begin
                    best_stamp_reg <= stamp_q;
                    best_tag_reg   <= tag_q;
                    best_line_reg  <= cur_line_reg;
                end
            end
            ST_VICT: begin
                j_reg <= 3'd0;
                if (found_inv_reg) begin
                    line_reg <= inv_line_reg;
                end else begin
                    line_reg       <= best_line_reg;
                    wb_base_reg    <= 16'(best_tag_reg << eff_b);
                    vict_dirty_reg <= dirty_reg[best_line_reg];
                end
            end
            ST_WB_WR: j_reg <= j_reg + 3'd1;
            ST_WB_EMIT: j_reg <= 3'd0;
            ST_FILL_WR: j_reg <= j_reg + 3'd1;
            ST_FL_TAG: wb_base_reg <= 16'(tag_q << eff_b);
            default: ;
        endcase
    end

    // configuration, line status and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bw_log2_reg   <= 2'd2;
            sets_log2_reg <= 4'd4;
            ways_log2_reg <= 2'd1;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_fire) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (cfg_wr_en) begin
                case (cfg_index)
                    sawbc_pkg::REG_BLOCK_WORDS_LOG2: bw_log2_reg <= cfg_wr_data[1:0];
                    sawbc_pkg::REG_SETS_LOG2:        sets_log2_reg <= cfg_wr_data;
                    sawbc_pkg::REG_WAYS_LOG2:        ways_log2_reg <= cfg_wr_data[1:0];
                    default: ;
                endcase
                valid_reg <= '0;
                dirty_reg <= '0;
            end
            case (state_reg)
                ST_WB_EMIT: begin
                    if (can_emit) begin
                        m_data_reg.transfer_kind <= vict_dirty_reg ? sawbc_pkg::XFER_C2M
                                                                   : sawbc_pkg::XFER_DROP;
                        m_data_reg.start_address <= wb_base_reg;
                        m_data_reg.word_count    <= bs;
                        m_data_reg.read_word     <= '0;
                        m_data_reg.last          <= is_flush_reg;
                        if (is_flush_reg) dirty_reg[line_reg] <= 1'b0;
                    end
                end
                ST_FILL_EMIT: begin
                    if (can_emit) begin
                        m_data_reg.transfer_kind <= sawbc_pkg::XFER_M2C;
                        m_data_reg.start_address <= fill_base;
                        m_data_reg.word_count    <= bs;
                        m_data_reg.read_word     <= '0;
                        m_data_reg.last          <= 1'b0;
                        valid_reg[line_reg] <= 1'b1;
                        dirty_reg[line_reg] <= 1'b0;
                    end
                end
                ST_ACC: if (!is_read_reg) dirty_reg[line_reg] <= 1'b1;
                ST_ACC_EMIT: begin
                    if (can_emit) begin
                        m_data_reg.transfer_kind <= is_read_reg ? sawbc_pkg::XFER_C2P
                                                                : sawbc_pkg::XFER_P2C;
                        m_data_reg.start_address <= addr_reg;
                        m_data_reg.word_count    <= 4'd1;
                        m_data_reg.read_word     <= is_read_reg ? lw_q : 32'd0;
                        m_data_reg.last          <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/set_assoc_write_back_cache_core.sv =====
// channel   | ports                   | direction | transaction
// ----------+-------------------------+-----------+----------------------------
// command   | s_valid s_ready s_data  | in        | one command
// result    | m_valid m_ready m_data  | out       | one transfer report
// config    | cfg_wr_en cfg_index ... | in        | one register write
//
// preload writes the backing memory directly; a flush of a dirty line
// reads its tag, then writes the block back word by word; a read/write
// searches the ways one at a time, then on a miss writes back or drops any
// victim and fills the block word by word through the single-port memories.
// each result waits for m_ready; a two-entry command queue keeps accepting,
// until it is full, while the back end works or stalls.
// aresetn (synchronous) clears valid/dirty bits and restores default geometry.
module set_assoc_write_back_cache_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sawbc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sawbc_pkg::out_item_t m_data
);

    sawbc_pkg::q_head_t q_head;
    logic q_pop;

    // command intake and queue
    sawbc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    // cache engine
    sawbc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
